>>> hdl/stt_pkg.sv
// Shared types, constants and helpers for the source text tokenizer.
// No dependencies; every other file of the block but stt_if imports this package.
package stt_pkg;

  // Default widths of the position and length counters
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned LENGTH_BITS_DEF   = 16;

  // Entries of the queue between classifier and lexer
  localparam int unsigned QUEUE_DEPTH = 4;

  // Keywords are matched on at most this many characters
  localparam int unsigned WORD_CHARS  = 6;
  localparam int unsigned PREFIX_BITS = 8 * WORD_CHARS;
  localparam int unsigned KW_COUNT    = 8;

  // Character codes the lexer looks at
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  // Keyword text, right aligned: let fn if else while return true false
  localparam logic [PREFIX_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    48'h0000_006C_6574,
    48'h0000_0000_666E,
    48'h0000_0000_6966,
    48'h0000_656C_7365,
    48'h0077_6869_6C65,
    48'h7265_7475_726E,
    48'h0000_7472_7565,
    48'h0066_616C_7365
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd5, 3'd6, 3'd4, 3'd5};

  typedef enum logic [2:0] {
    KIND_IDENT   = 3'd0,
    KIND_KEYWORD = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_OP      = 3'd4,
    KIND_PUNCT   = 3'd5,
    KIND_UNKNOWN = 3'd6,
    KIND_END     = 3'd7
  } token_kind_e;

  // Byte classes found by the front end
  typedef enum logic [3:0] {
    CLS_END,
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_ALPHA,
    CLS_DIGIT,
    CLS_DOT,
    CLS_QUOTE,
    CLS_SLASH,
    CLS_OPCH,
    CLS_PUNCT,
    CLS_OTHER
  } char_class_e;

  // One classified byte
  typedef struct packed {
    char_class_e cls;
    logic [7:0]  ch;
  } item_t;

  // One token record
  typedef struct packed {
    token_kind_e kind;
    logic [2:0]  keyword_index;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic        last_of_run;
  } token_t;

  // Two-character operators: == != <= >= += && ||
  function automatic logic op_pair(input logic [7:0] a, input logic [7:0] b);
    logic r;
    if (b == CH_EQ) begin
      r = (a == CH_EQ) || (a == CH_BANG) || (a == CH_LT) || (a == CH_GT) || (a == CH_PLUS);
    end else begin
      r = ((a == CH_AMP) && (b == CH_AMP)) || ((a == CH_BAR) && (b == CH_BAR));
    end
    return r;
  endfunction

  function automatic token_t make_rec(input token_kind_e kind, input logic [2:0] kw,
                                      input logic [7:0] c1, input logic [7:0] c2,
                                      input logic [15:0] line, input logic [15:0] col,
                                      input logic [15:0] len);
    token_t r;
    r.kind          = kind;
    r.keyword_index = kw;
    r.first_char    = c1;
    r.second_char   = c2;
    r.start_line    = line;
    r.start_column  = col;
    r.token_length  = len;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

endpackage

>>> hdl/stt_if.sv
// Handshake channels of the tokenizer: source bytes in, token records out.
// No dependencies.
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface stt_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [2:0]  keyword_index;
  logic [7:0]  first_char;
  logic [7:0]  second_char;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output keyword_index, output first_char,
                  output second_char, output start_line, output start_column,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input keyword_index, input first_char,
                  input second_char, input start_line, input start_column,
                  input token_length, input last_of_run, output ready);
endinterface

>>> hdl/stt_front.sv
// Front end: accepts source bytes and tags each with its character class.
// Depends on stt_pkg and the stt_byte_if interface.
module stt_front (
  stt_byte_if.sink       byte_i,
  input  logic           full_i,
  output logic           push_o,
  output stt_pkg::item_t item_o
);
  import stt_pkg::*;

  function automatic char_class_e classify(input logic [7:0] c, input logic eoi);
    char_class_e r;
    if (eoi || (c == 8'h00)) begin
      r = CLS_END;
    end else begin
      case (c) inside
        8'h0A:                           r = CLS_NEWLINE;
        8'h20, [8'h09:8'h0D]:            r = CLS_SPACE;
        [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: r = CLS_ALPHA;
        [8'h30:8'h39]:                   r = CLS_DIGIT;
        8'h2E:                           r = CLS_DOT;
        8'h22:                           r = CLS_QUOTE;
        8'h2F:                           r = CLS_SLASH;
        8'h2B, 8'h2D, 8'h2A, 8'h3D, 8'h3C, 8'h3E, 8'h21, 8'h26, 8'h7C: r = CLS_OPCH;
        8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B, 8'h2C: r = CLS_PUNCT;
        default:                         r = CLS_OTHER;
      endcase
    end
    return r;
  endfunction

  // Accept whenever the queue has room
  assign byte_i.ready = !full_i;
  assign push_o       = byte_i.valid && !full_i;
  assign item_o.cls   = classify(byte_i.ch, byte_i.end_of_input);
  assign item_o.ch    = byte_i.ch;

endmodule

>>> hdl/stt_queue.sv
// Short FIFO of classified bytes between the front end and the lexer.
// Depends on stt_pkg.
module stt_queue #(
  parameter int unsigned DEPTH = stt_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  stt_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output stt_pkg::item_t data_o
);
  import stt_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> hdl/stt_back.sv
// Back end: lexer state machine over classified bytes, with the output register.
// Depends on stt_pkg and the stt_token_if interface.
module stt_back #(
  parameter int unsigned POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = stt_pkg::LENGTH_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  stt_pkg::item_t item_i,
  output logic           pop_o,
  stt_token_if.source    token_o
);
  import stt_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_OP,
    MODE_COMMENT
  } mode_e;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
  localparam logic [POSITION_BITS+15:0] POS_CAP = (POSITION_BITS + 16)'(16'hFFFF);
  localparam logic [LENGTH_BITS+15:0]   LEN_CAP = (LENGTH_BITS + 16)'(16'hFFFF);

  function automatic logic [15:0] sat_pos(input logic [POSITION_BITS-1:0] v);
    logic [POSITION_BITS+15:0] w;
    w = {16'd0, v};
    return (w > POS_CAP) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [15:0] sat_len(input logic [LENGTH_BITS-1:0] v);
    logic [LENGTH_BITS+15:0] w;
    w = {16'd0, v};
    return (w > LEN_CAP) ? 16'hFFFF : w[15:0];
  endfunction

  mode_e                    mode_q, mode_d;
  logic [7:0]               pend_q, pend_d;
  logic [PREFIX_BITS-1:0]   prefix_q, prefix_d;
  logic [LENGTH_BITS-1:0]   run_q, run_d, run_inc;
  logic [POSITION_BITS-1:0] tok_line_q, tok_line_d, tok_col_q, tok_col_d;
  logic [POSITION_BITS-1:0] cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic                     phase_q;
  logic                     out_valid_q;
  token_t                   out_q;

  logic        is_end, fall, move;
  logic        has_a, has_b;
  token_t      rec_a, rec_b, rec_sel;
  token_kind_e word_kind;
  logic [2:0]  word_idx;
  logic        can_load, load, take;
  logic [1:0]  n_rec;

  assign is_end  = (item_i.cls == CLS_END);
  assign run_inc = (run_q < LEN_MAX) ? run_q + 1'b1 : run_q;

  // Keyword lookup over the eight fixed words
  always_comb begin
    word_kind = KIND_IDENT;
    word_idx  = '0;
    if (run_q <= LENGTH_BITS'(WORD_CHARS)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if ((run_q == LENGTH_BITS'(KW_LEN[i])) && (prefix_q == KW_TEXT[i])) begin
          word_kind = KIND_KEYWORD;
          word_idx  = 3'(i);
        end
      end
    end
  end

  // Mode logic: records caused by the head byte and the next lexer state
  always_comb begin
    mode_d     = mode_q;
    pend_d     = pend_q;
    prefix_d   = prefix_q;
    run_d      = run_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    fall       = 1'b0;
    move       = 1'b0;
    has_a      = 1'b0;
    has_b      = 1'b0;
    rec_a      = make_rec(KIND_END, '0, '0, '0, sat_pos(tok_line_q), sat_pos(tok_col_q), '0);
    rec_b      = make_rec(KIND_END, '0, '0, '0, sat_pos(cur_line_q), sat_pos(cur_col_q), '0);

    // close or extend the open token
    case (mode_q)
      MODE_IDENT: begin
        if (!is_end && ((item_i.cls == CLS_ALPHA) || (item_i.cls == CLS_DIGIT))) begin
          if (run_q < LENGTH_BITS'(WORD_CHARS)) begin
            prefix_d = {prefix_q[PREFIX_BITS-9:0], item_i.ch};
          end
          run_d = run_inc;
          move  = 1'b1;
        end else begin
          has_a = 1'b1;
          rec_a = make_rec(word_kind, word_idx, '0, '0, sat_pos(tok_line_q),
                           sat_pos(tok_col_q), sat_len(run_q));
          fall  = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (!is_end && ((item_i.cls == CLS_DIGIT) || (item_i.cls == CLS_DOT))) begin
          run_d = run_inc;
          move  = 1'b1;
        end else begin
          has_a = 1'b1;
          rec_a = make_rec(KIND_NUMBER, '0, '0, '0, sat_pos(tok_line_q),
                           sat_pos(tok_col_q), sat_len(run_q));
          fall  = 1'b1;
        end
      end
      MODE_STRING: begin
        if (is_end || (item_i.cls == CLS_QUOTE)) begin
          has_a  = 1'b1;
          rec_a  = make_rec(KIND_STRING, '0, '0, '0, sat_pos(tok_line_q),
                            sat_pos(tok_col_q), sat_len(run_q));
          mode_d = MODE_IDLE;
          // end of text still gives the end record; a closing quote does not
          fall   = is_end;
          move   = !is_end;
        end else begin
          run_d = run_inc;
          move  = 1'b1;
        end
      end
      MODE_OP: begin
        if (!is_end && (pend_q == CH_SLASH) && (item_i.cls == CLS_SLASH)) begin
          mode_d = MODE_COMMENT;
          move   = 1'b1;
        end else if (!is_end && op_pair(pend_q, item_i.ch)) begin
          has_a  = 1'b1;
          rec_a  = make_rec(KIND_OP, '0, pend_q, item_i.ch, sat_pos(tok_line_q),
                            sat_pos(tok_col_q), 16'd2);
          mode_d = MODE_IDLE;
          move   = 1'b1;
        end else begin
          has_a = 1'b1;
          rec_a = make_rec(((pend_q == CH_AMP) || (pend_q == CH_BAR)) ? KIND_UNKNOWN : KIND_OP,
                           '0, pend_q, '0, sat_pos(tok_line_q), sat_pos(tok_col_q), 16'd1);
          fall  = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (!is_end && (item_i.cls != CLS_NEWLINE)) begin
          move = 1'b1;
        end else begin
          fall = 1'b1;
        end
      end
      default: begin
        fall = 1'b1;
      end
    endcase

    // idle: the byte starts something new, or ends the text
    if (fall) begin
      mode_d = MODE_IDLE;
      if (is_end) begin
        has_b = 1'b1;
      end else begin
        tok_line_d = cur_line_q;
        tok_col_d  = cur_col_q;
        move       = 1'b1;
        case (item_i.cls)
          CLS_ALPHA: begin
            mode_d   = MODE_IDENT;
            prefix_d = PREFIX_BITS'(item_i.ch);
            run_d    = LENGTH_BITS'(1);
          end
          CLS_DIGIT: begin
            mode_d = MODE_NUMBER;
            run_d  = LENGTH_BITS'(1);
          end
          CLS_QUOTE: begin
            mode_d = MODE_STRING;
            run_d  = '0;
          end
          CLS_SLASH, CLS_OPCH: begin
            mode_d = MODE_OP;
            pend_d = item_i.ch;
            run_d  = LENGTH_BITS'(1);
          end
          CLS_PUNCT: begin
            has_b = 1'b1;
            rec_b = make_rec(KIND_PUNCT, '0, item_i.ch, '0, sat_pos(cur_line_q),
                             sat_pos(cur_col_q), 16'd1);
          end
          CLS_OTHER, CLS_DOT: begin
            has_b = 1'b1;
            rec_b = make_rec(KIND_UNKNOWN, '0, item_i.ch, '0, sat_pos(cur_line_q),
                             sat_pos(cur_col_q), 16'd1);
          end
          default: begin
            // whitespace is skipped
          end
        endcase
      end
    end

    // position tracking
    if (move) begin
      if (item_i.cls == CLS_NEWLINE) begin
        cur_line_d = (cur_line_q < POS_MAX) ? cur_line_q + 1'b1 : cur_line_q;
        cur_col_d  = POSITION_BITS'(1);
      end else if (cur_col_q < POS_MAX) begin
        cur_col_d = cur_col_q + 1'b1;
      end
    end
  end

  // Record sequencing: a byte with two records holds the queue head until both are loaded
  assign n_rec    = {1'b0, has_a} + {1'b0, has_b};
  assign can_load = !out_valid_q || token_o.ready;
  assign take     = valid_i && can_load;
  assign load     = take && (n_rec != 2'd0);
  assign pop_o    = take && ((n_rec != 2'd2) || phase_q);

  always_comb begin
    if (n_rec == 2'd2) begin
      rec_sel             = phase_q ? rec_b : rec_a;
      rec_sel.last_of_run = phase_q;
    end else begin
      rec_sel             = has_a ? rec_a : rec_b;
      rec_sel.last_of_run = 1'b1;
    end
  end

  // Lexer state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      pend_q      <= '0;
      prefix_q    <= '0;
      run_q       <= '0;
      tok_line_q  <= POSITION_BITS'(1);
      tok_col_q   <= POSITION_BITS'(1);
      cur_line_q  <= POSITION_BITS'(1);
      cur_col_q   <= POSITION_BITS'(1);
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (can_load) begin
        out_valid_q <= load;
      end
      if (take && (n_rec == 2'd2)) begin
        phase_q <= !phase_q;
      end
      if (pop_o) begin
        mode_q     <= mode_d;
        pend_q     <= pend_d;
        prefix_q   <= prefix_d;
        run_q      <= run_d;
        tok_line_q <= tok_line_d;
        tok_col_q  <= tok_col_d;
        cur_line_q <= cur_line_d;
        cur_col_q  <= cur_col_d;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= rec_sel;
    end
  end

  assign token_o.valid         = out_valid_q;
  assign token_o.token_kind    = out_q.kind;
  assign token_o.keyword_index = out_q.keyword_index;
  assign token_o.first_char    = out_q.first_char;
  assign token_o.second_char   = out_q.second_char;
  assign token_o.start_line    = out_q.start_line;
  assign token_o.start_column  = out_q.start_column;
  assign token_o.token_length  = out_q.token_length;
  assign token_o.last_of_run   = out_q.last_of_run;

endmodule

>>> hdl/source_text_tokenizer_top.sv
// Top level of the source text tokenizer: front end, queue, lexer back end.
// Depends on stt_pkg, stt_if, stt_front, stt_queue and stt_back.
//
//   channel   direction  handshake      payload
//   byte_i    in         valid/ready    ch, end_of_input
//   token_o   out        valid/ready    token record fields, last_of_run
//
// A byte is taken every cycle while the queue has room; the lexer retires one byte
// per cycle while the output is not stalled; a byte that closes one token and emits
// a second record is held for both. Records leave through a registered output stage.
// Reset clears the queue, the lexer state (positions back to line 1, column 1)
// and the output valid. A stalled output fills the queue, then drops byte_i.ready.
module source_text_tokenizer_top #(
  parameter int unsigned POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = stt_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stt_byte_if.sink    byte_i,
  stt_token_if.source token_o
);
  import stt_pkg::*;

  logic  push, full, pop, head_valid;
  item_t push_item, head_item;

  stt_front u_front (
    .byte_i (byte_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  stt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_item)
  );

  stt_back #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .item_i  (head_item),
    .pop_o   (pop),
    .token_o (token_o)
  );

  // Second record of a byte follows right after the first is taken
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_o.valid && token_o.ready && !token_o.last_of_run |=> token_o.valid)
    else $error("second record of a byte did not follow");

  // A byte only leaves the queue once its last record is loaded or it has none
  a_pop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !token_o.valid || token_o.last_of_run || !$past(token_o.valid) ||
            $past(token_o.ready))
    else $error("queue head retired while a record was pending");

  // End records carry no text
  a_end_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_o.valid && (token_o.token_kind == KIND_END) |->
      (token_o.token_length == 16'd0) && (token_o.first_char == 8'd0) &&
      token_o.last_of_run)
    else $error("malformed end record");

  // Positions count from one
  a_position_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_o.valid |-> (token_o.start_line != 16'd0) && (token_o.start_column != 16'd0))
    else $error("zero start position");

endmodule
